FILE: hw/rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the supply and silence supervisor
// Beat layouts, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WCOUNT_W   = 5;
  localparam int unsigned SUM_W      = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY_LOW_ON    = 3'd0,
    CFG_SUPPLY_LOW_OFF   = 3'd1,
    CFG_CHARGE_ON_BELOW  = 3'd2,
    CFG_CHARGE_OFF_ABOVE = 3'd3,
    CFG_MIN_AUDIO_LEVEL  = 3'd4,
    CFG_PERIOD_LIMIT     = 3'd5,
    CFG_HOLD_TICKS       = 3'd6
  } cfg_index_t;

  localparam logic [7:0]  RST_SUPPLY_LOW_ON    = 8'd125;
  localparam logic [7:0]  RST_SUPPLY_LOW_OFF   = 8'd146;
  localparam logic [7:0]  RST_CHARGE_ON_BELOW  = 8'd160;
  localparam logic [7:0]  RST_CHARGE_OFF_ABOVE = 8'd158;
  localparam logic [9:0]  RST_MIN_AUDIO_LEVEL  = 10'd10;
  localparam logic [15:0] RST_PERIOD_LIMIT     = 16'd7714;
  localparam logic [7:0]  RST_HOLD_TICKS       = 8'd20;
  localparam logic [SUM_W-1:0] RST_LEVEL_SUM   = 17'd65535;

  localparam logic MODE_SUPPLY = 1'b0;
  localparam logic MODE_TIMER  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] supply_sample;
    logic [9:0] audio_sample;
  } item_t;

  typedef struct packed {
    logic player_reset;
    logic charge_enable;
    logic resend_request;
    logic forced_reset;
  } result_t;

  typedef struct packed {
    logic [7:0]  supply_low_on;
    logic [7:0]  supply_low_off;
    logic [7:0]  charge_on_below;
    logic [7:0]  charge_off_above;
    logic [9:0]  min_audio_level;
    logic [15:0] period_limit;
    logic [7:0]  hold_ticks;
  } cfg_t;

endpackage

FILE: hw/rtl/supply_and_silence_supervisor_core.sv
// ----------------------------------------------------------------------------
// supply_and_silence_supervisor_core: player supply and silence supervisor
// Path: an accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle while the result is not stalled; the state
// update is combinational logic between the input and result registers.
// Reset: rst clears both valid flags, presets state, loads register defaults.
// ----------------------------------------------------------------------------
module supply_and_silence_supervisor_core #(
  parameter int unsigned WINDOW_LEN = 30
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  sss_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output sss_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sss_pkg::*;

  cfg_t    cfg;
  item_t   stage;        // input register
  logic    stage_valid;
  logic    advance;      // stage beat moves into the result register
  result_t result_next;

  sss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sss_core_logic #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_logic (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (stage),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // The result register takes a new beat whenever it is empty or draining.
  assign advance    = stage_valid && (!result_valid || !result_stall);
  // Hold the input side only while the stage is full and cannot move on.
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A resend pulse is only raised on the beat that releases the player.
  a_resend_released: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.resend_request && result.player_reset))
    else $error("resend request raised while player held in reset");

  // The input side is only held when a beat waits behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (stage_valid && result_valid && result_stall))
    else $error("input stalled without a blocked result");

  // A new result appears only from a beat that sat in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid))
    else $error("result valid without a staged beat");

endmodule

FILE: hw/rtl/sss_cfg_regs.sv
// ----------------------------------------------------------------------------
// sss_cfg_regs: configuration register file
// Write-only threshold and timing registers with their reset values.
// ----------------------------------------------------------------------------
module sss_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0]      cfg_data,
  output sss_pkg::cfg_t                       cfg
);
  import sss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply_low_on    <= RST_SUPPLY_LOW_ON;
      cfg.supply_low_off   <= RST_SUPPLY_LOW_OFF;
      cfg.charge_on_below  <= RST_CHARGE_ON_BELOW;
      cfg.charge_off_above <= RST_CHARGE_OFF_ABOVE;
      cfg.min_audio_level  <= RST_MIN_AUDIO_LEVEL;
      cfg.period_limit     <= RST_PERIOD_LIMIT;
      cfg.hold_ticks       <= RST_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SUPPLY_LOW_ON:    cfg.supply_low_on    <= cfg_data[7:0];
        CFG_SUPPLY_LOW_OFF:   cfg.supply_low_off   <= cfg_data[7:0];
        CFG_CHARGE_ON_BELOW:  cfg.charge_on_below  <= cfg_data[7:0];
        CFG_CHARGE_OFF_ABOVE: cfg.charge_off_above <= cfg_data[7:0];
        CFG_MIN_AUDIO_LEVEL:  cfg.min_audio_level  <= cfg_data[9:0];
        CFG_PERIOD_LIMIT:     cfg.period_limit     <= cfg_data[15:0];
        CFG_HOLD_TICKS:       cfg.hold_ticks       <= cfg_data[7:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

endmodule

FILE: hw/rtl/sss_core_logic.sv
// ----------------------------------------------------------------------------
// sss_core_logic: supervisor state and per-beat update
// Holds supply, charge, hold, period and audio window state; computes the
// result of one beat and commits the new state when the beat advances.
// ----------------------------------------------------------------------------
module sss_core_logic #(
  parameter int unsigned WINDOW_LEN = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  sss_pkg::item_t   item,
  input  sss_pkg::cfg_t    cfg,
  output sss_pkg::result_t result_next
);
  import sss_pkg::*;

  localparam logic [WCOUNT_W-1:0] WIN_LEN = WCOUNT_W'(WINDOW_LEN);

  logic                supply_low, supply_low_next;
  logic                charge_on, charge_on_next;
  logic                forced_pending, forced_pending_next;
  logic [7:0]          hold_count, hold_count_next;
  logic [15:0]         period_count, period_count_next;
  logic [WCOUNT_W-1:0] window_count, window_count_next;
  logic [SUM_W-1:0]    level_sum, level_sum_next;
  logic                resend_pending, resend_pending_next;
  logic                reset_line, reset_line_next;
  logic                resend;
  logic [SUM_W-1:0]    silence_limit;

  // Floor average below the minimum is the same as the sum below min * window.
  assign silence_limit = SUM_W'(cfg.min_audio_level) * SUM_W'(WINDOW_LEN);

  always_comb begin
    supply_low_next     = supply_low;
    charge_on_next      = charge_on;
    forced_pending_next = forced_pending;
    hold_count_next     = hold_count;
    period_count_next   = period_count;
    window_count_next   = window_count;
    level_sum_next      = level_sum;
    resend_pending_next = resend_pending;
    reset_line_next     = reset_line;
    resend              = 1'b0;

    if (item.mode == MODE_SUPPLY) begin
      if (item.supply_sample < cfg.supply_low_on)    supply_low_next = 1'b1;
      if (item.supply_sample > cfg.supply_low_off)   supply_low_next = 1'b0;
      if (item.supply_sample < cfg.charge_on_below)  charge_on_next  = 1'b1;
      if (item.supply_sample > cfg.charge_off_above) charge_on_next  = 1'b0;
      if (hold_count != 8'd0) hold_count_next = hold_count - 8'd1;
      if (hold_count_next == 8'd0) forced_pending_next = 1'b0;
      if (forced_pending_next || supply_low_next) begin
        reset_line_next     = 1'b1;
        resend_pending_next = 1'b1;
      end else begin
        reset_line_next     = 1'b0;
        resend              = resend_pending;
        resend_pending_next = 1'b0;
      end
    end else begin
      period_count_next = period_count + 16'd1;
      if (period_count_next > cfg.period_limit) begin
        hold_count_next     = cfg.hold_ticks;
        forced_pending_next = 1'b1;
        period_count_next   = 16'd0;
      end
      if (!supply_low) begin
        level_sum_next    = level_sum + SUM_W'(item.audio_sample);
        window_count_next = window_count + WCOUNT_W'(1);
        if (window_count_next >= WIN_LEN) begin
          if (level_sum_next < silence_limit) begin
            hold_count_next     = cfg.hold_ticks;
            forced_pending_next = 1'b1;
          end
          window_count_next = '0;
          level_sum_next    = '0;
        end
      end
    end

    result_next.player_reset   = reset_line_next;
    result_next.charge_enable  = charge_on_next;
    result_next.resend_request = resend;
    result_next.forced_reset   = forced_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_low     <= 1'b0;
      charge_on      <= 1'b0;
      forced_pending <= 1'b0;
      hold_count     <= 8'd0;
      period_count   <= 16'd0;
      window_count   <= '0;
      level_sum      <= RST_LEVEL_SUM;
      resend_pending <= 1'b0;
      reset_line     <= 1'b0;
    end else if (advance) begin
      supply_low     <= supply_low_next;
      charge_on      <= charge_on_next;
      forced_pending <= forced_pending_next;
      hold_count     <= hold_count_next;
      period_count   <= period_count_next;
      window_count   <= window_count_next;
      level_sum      <= level_sum_next;
      resend_pending <= resend_pending_next;
      reset_line     <= reset_line_next;
    end
  end

endmodule

FILE: dv/tb_supply_and_silence_supervisor_core.sv
// ----------------------------------------------------------------------------
// tb_supply_and_silence_supervisor_core: self-checking bench for the supervisor
// Drives supply and timer beats in random bursts against a stalling receiver.
// A cycle-free mirror of the supervisor state predicts every result beat,
// across register settings that include the all-zero and all-max extremes.
// ----------------------------------------------------------------------------
module tb_supply_and_silence_supervisor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int WINDOW_LEN = 30;
  localparam int ITEM_W     = $bits(item_t);

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  supply_and_silence_supervisor_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the supervisor: register copy, full state, and the queue of
  // result beats still owed by the block.
  class supervisor_mirror;
    cfg_t                regs;
    logic                supply_low, charge_on, forced_pending;
    logic                reset_latch, resend_pending;
    logic [7:0]          hold_count;
    logic [15:0]         period_count;
    logic [WCOUNT_W-1:0] window_count;
    logic [SUM_W-1:0]    level_sum;
    result_t             owed_results[$];
    int                  errors, supply_ticks, timer_ticks, forced_arms, resend_pulses;

    function new();
      regs = '{RST_SUPPLY_LOW_ON, RST_SUPPLY_LOW_OFF, RST_CHARGE_ON_BELOW,
               RST_CHARGE_OFF_ABOVE, RST_MIN_AUDIO_LEVEL, RST_PERIOD_LIMIT,
               RST_HOLD_TICKS};
      supply_low     = 1'b0;
      charge_on      = 1'b0;
      forced_pending = 1'b0;
      reset_latch    = 1'b0;
      resend_pending = 1'b0;
      hold_count     = '0;
      period_count   = '0;
      window_count   = '0;
      level_sum      = RST_LEVEL_SUM;
      errors         = 0;
      supply_ticks   = 0;
      timer_ticks    = 0;
      forced_arms    = 0;
      resend_pulses  = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SUPPLY_LOW_ON:    regs.supply_low_on    = val[7:0];
        CFG_SUPPLY_LOW_OFF:   regs.supply_low_off   = val[7:0];
        CFG_CHARGE_ON_BELOW:  regs.charge_on_below  = val[7:0];
        CFG_CHARGE_OFF_ABOVE: regs.charge_off_above = val[7:0];
        CFG_MIN_AUDIO_LEVEL:  regs.min_audio_level  = val[9:0];
        CFG_PERIOD_LIMIT:     regs.period_limit     = val[15:0];
        CFG_HOLD_TICKS:       regs.hold_ticks       = val[7:0];
        default: ;
      endcase
    endfunction

    function void arm_forced();
      hold_count     = regs.hold_ticks;
      forced_pending = 1'b1;
      forced_arms++;
    endfunction

    function void take_item(item_t it);
      result_t want;
      logic    resend;
      resend = 1'b0;
      if (it.mode == MODE_SUPPLY) begin
        supply_ticks++;
        // Thresholds apply in order: the clearing rule wins on overlap.
        if (it.supply_sample < regs.supply_low_on) supply_low = 1'b1;
        if (it.supply_sample > regs.supply_low_off) supply_low = 1'b0;
        if (it.supply_sample < regs.charge_on_below) charge_on = 1'b1;
        if (it.supply_sample > regs.charge_off_above) charge_on = 1'b0;
        if (hold_count != 0) hold_count--;
        if (hold_count == 0) forced_pending = 1'b0;
        if (forced_pending || supply_low) begin
          reset_latch    = 1'b1;
          resend_pending = 1'b1;
        end else begin
          reset_latch = 1'b0;
          if (resend_pending) begin
            resend         = 1'b1;
            resend_pending = 1'b0;
            resend_pulses++;
          end
        end
      end else begin
        timer_ticks++;
        period_count = period_count + 16'd1;
        if (period_count > regs.period_limit) begin
          arm_forced();
          period_count = '0;
        end
        // Audio only counts while the supply is good.
        if (!supply_low) begin
          level_sum    = level_sum + SUM_W'(it.audio_sample);
          window_count = window_count + WCOUNT_W'(1);
          if (window_count > WINDOW_LEN - 1) begin
            if (level_sum / WINDOW_LEN < regs.min_audio_level) arm_forced();
            window_count = '0;
            level_sum    = '0;
          end
        end
      end
      want = '{reset_latch, charge_on, resend, forced_pending};
      owed_results.push_back(want);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void check_outputs(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        flag($sformatf("result beat %b with nothing owed", got));
        return;
      end
      want = owed_results.pop_front();
      if (got.player_reset !== want.player_reset ||
          got.charge_enable !== want.charge_enable ||
          got.resend_request !== want.resend_request ||
          got.forced_reset !== want.forced_reset)
        flag($sformatf({"reset/charge/resend/forced expected %b%b%b%b, ",
                        "got %b%b%b%b"},
                       want.player_reset, want.charge_enable,
                       want.resend_request, want.forced_reset,
                       got.player_reset, got.charge_enable,
                       got.resend_request, got.forced_reset));
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void close_out();
      if (owed_results.size() != 0)
        flag($sformatf("%0d result beats never arrived", owed_results.size()));
    endfunction
  endclass

  supervisor_mirror mirror = new();
  cfg_t             live_cfg = '{RST_SUPPLY_LOW_ON, RST_SUPPLY_LOW_OFF,
                                 RST_CHARGE_ON_BELOW, RST_CHARGE_OFF_ABOVE,
                                 RST_MIN_AUDIO_LEVEL, RST_PERIOD_LIMIT,
                                 RST_HOLD_TICKS};
  int               settings_run = 1;
  int               burst_left   = 0;
  int               gap_cap      = 6;

  // Sample both handshakes at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) mirror.take_item(item);
      if (result_valid && !result_stall) mirror.check_outputs(result);
    end
  end

  // Receiver back-pressure: pick a stall style for a random stretch, then
  // hold it. Styles run from no stall at all to mostly stalled.
  int stall_left  = 0;
  int stall_style = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= stall_phase[2];
    endcase
  end

  // Send one beat; called and returns at a falling edge. Open a new burst
  // after a random gap, with junk on the payload while valid is low.
  task automatic push_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_cap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_cap);
      if (gap > 0) begin
        item_valid <= 1'b0;
        item       <= item_t'(ITEM_W'($urandom));
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result beat is back, then let the
  // pipeline settle.
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    while (mirror.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write every register back to back; junk rides in the unused high bits.
  task automatic apply_setting(input cfg_t c);
    cfg_index_t           idx;
    logic [CFG_DATA_W-1:0] val;
    for (int k = 0; k < 7; k++) begin
      idx = cfg_index_t'(k);
      val = CFG_DATA_W'($urandom);
      case (idx)
        CFG_SUPPLY_LOW_ON:    val[7:0]  = c.supply_low_on;
        CFG_SUPPLY_LOW_OFF:   val[7:0]  = c.supply_low_off;
        CFG_CHARGE_ON_BELOW:  val[7:0]  = c.charge_on_below;
        CFG_CHARGE_OFF_ABOVE: val[7:0]  = c.charge_off_above;
        CFG_MIN_AUDIO_LEVEL:  val[9:0]  = c.min_audio_level;
        CFG_PERIOD_LIMIT:     val       = c.period_limit;
        default:              val[7:0]  = c.hold_ticks;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(negedge clk);
      mirror.set_reg(idx, val);
    end
    cfg_we   <= 1'b0;
    live_cfg = c;
    settings_run++;
  endtask

  // Supply samples cluster around the live thresholds two thirds of the time.
  function automatic logic [7:0] pick_supply();
    int v;
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(0, 255));
      2: v = int'(live_cfg.supply_low_on);
      3: v = int'(live_cfg.supply_low_off);
      4: v = int'(live_cfg.charge_on_below);
      default: v = int'(live_cfg.charge_off_above);
    endcase
    v = v + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic item_t random_item(input int timer_pct, input bit quiet);
    item_t it;
    int    hi;
    it.mode          = ($urandom_range(0, 99) < timer_pct) ? MODE_TIMER : MODE_SUPPLY;
    it.supply_sample = pick_supply();
    if (quiet && $urandom_range(0, 3) != 0) begin
      // Stay near the minimum level so window averages straddle it.
      hi = 2 * live_cfg.min_audio_level + 2;
      if (hi > 1023) hi = 1023;
      it.audio_sample = 10'($urandom_range(0, hi));
    end else begin
      case ($urandom_range(0, 4))
        0: it.audio_sample = 10'd0;
        1: it.audio_sample = 10'h3FF;
        default: it.audio_sample = 10'($urandom_range(0, 1023));
      endcase
    end
    return it;
  endfunction

  task automatic run_phase(input int count, input int timer_pct, input int cap);
    bit quiet;
    quiet   = 1'($urandom_range(0, 1));
    gap_cap = cap;
    for (int k = 0; k < count; k++) push_item(random_item(timer_pct, quiet));
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.supply_low_on    = 8'($urandom_range(0, 255));
    c.supply_low_off   = 8'($urandom_range(0, 255));
    // Mostly a proper hysteresis band; sometimes crossed.
    if ($urandom_range(0, 3) != 0 && c.supply_low_on > c.supply_low_off) begin
      c.supply_low_on  = c.supply_low_on ^ c.supply_low_off;
      c.supply_low_off = c.supply_low_on ^ c.supply_low_off;
      c.supply_low_on  = c.supply_low_on ^ c.supply_low_off;
    end
    c.charge_on_below  = 8'($urandom_range(0, 255));
    c.charge_off_above = 8'($urandom_range(0, 255));
    c.min_audio_level  = 10'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 40));
    c.period_limit     = 16'($urandom_range(0, 80));
    c.hold_ticks       = 8'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic item_t fixed_item(input logic m, input logic [7:0] s,
                                       input logic [9:0] a);
    item_t it;
    it.mode          = m;
    it.supply_sample = s;
    it.audio_sample  = a;
    return it;
  endfunction

  initial begin
    item_t opening[$];
    cfg_t  c;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening beats at the reset defaults: walk each threshold edge, drop
    // into and out of supply low to get a resend pulse, and feed timer
    // beats while low so the audio window must ignore them.
    opening = '{fixed_item(MODE_SUPPLY, 8'd255, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd0, 10'h3FF),
                fixed_item(MODE_TIMER, 8'd0, 10'h3FF),
                fixed_item(MODE_TIMER, 8'hFF, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd146, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd147, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd125, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd124, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd159, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd158, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd160, 10'd0),
                fixed_item(MODE_SUPPLY, 8'd161, 10'd0),
                fixed_item(MODE_TIMER, 8'h55, 10'h2AA),
                fixed_item(MODE_TIMER, 8'hAA, 10'h155),
                fixed_item(MODE_SUPPLY, 8'h55, 10'h2AA),
                fixed_item(MODE_SUPPLY, 8'hAA, 10'h155)};
    gap_cap = 3;
    foreach (opening[k]) push_item(opening[k]);

    // Stay at the defaults long enough to close the first, offset window.
    run_phase(200, 70, 6);
    drain();

    // All zero: never low, periodic reset on every timer beat, zero hold.
    apply_setting('{8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 16'd0, 8'd0});
    run_phase(150, 55, 6);
    drain();

    // Silence reset on every window with the longest hold.
    apply_setting('{8'd0, 8'd255, 8'd255, 8'd255, 10'h3FF, 16'hFFFF, 8'd255});
    run_phase(150, 60, 6);
    drain();

    // All max: supply low latches and never clears, the period limit is out
    // of reach, and nearly all beats are timer beats, sent in bursts.
    apply_setting('{8'd255, 8'd255, 8'd255, 8'd255, 10'h3FF, 16'hFFFF, 8'd255});
    run_phase(34, 99, 1);
    drain();

    for (int p = 0; p < 6; p++) begin
      c = random_setting();
      apply_setting(c);
      run_phase(150, $urandom_range(40, 80), ($urandom_range(0, 2) == 0) ? 0
                                                 : $urandom_range(2, 8));
      drain();
    end

    // Late beats would still show up as unowed results here.
    for (int k = 0; k < 20000 && mirror.outstanding() != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);
    mirror.close_out();

    $display("Covered %0d supply beats and %0d timer beats over %0d register settings;",
             mirror.supply_ticks, mirror.timer_ticks, settings_run);
    $display("%0d forced resets armed, %0d resend pulses, %0d mismatches.",
             mirror.forced_arms, mirror.resend_pulses, mirror.errors);
    if (mirror.errors == 0) begin
      $display("tb_supply_and_silence_supervisor_core OK");
    end else begin
      $display("tb_supply_and_silence_supervisor_core NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("Timeout: %0d result beats still owed", mirror.outstanding());
    $display("tb_supply_and_silence_supervisor_core NOT OK");
    $finish;
  end

endmodule
